>>> hw/rtl/ashk_pkg.sv
// Package: shared types, constants and state encodings for the shake detector.
package ashk_pkg;

   localparam int MAX_EVENTS  = 16;
   localparam int SAMPLE_BITS = 16;
   localparam int EIDX_W      = $clog2(MAX_EVENTS);
   localparam int ECNT_W      = $clog2(MAX_EVENTS + 1);
   localparam int SQ_W        = 2 * SAMPLE_BITS + 2;
   localparam int MAG_W       = SAMPLE_BITS + 1;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_MAG  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REQ_EVT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW   = 2'd2;

   localparam logic [1:0] SIGN_ZERO = 2'd0;
   localparam logic [1:0] SIGN_POS  = 2'd1;
   localparam logic [1:0] SIGN_NEG  = 2'd2;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic [31:0]        time_ms;
      logic               restart;
   } req_type;

   typedef struct packed {
      logic [15:0] shake_level;
      logic [4:0]  event_count;
      logic        event_added;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_EXP_RD,
      ST_EXP_CHK,
      ST_ADD,
      ST_SQRT,
      ST_MAX_RD,
      ST_MAX_CHK,
      ST_DIV,
      ST_OUT
   } state_type;

   function automatic logic [1:0] sign_of(input logic signed [SAMPLE_BITS-1:0] v);
      if (v == '0)
         return SIGN_ZERO;
      else if (v[SAMPLE_BITS-1])
         return SIGN_NEG;
      else
         return SIGN_POS;
   endfunction

endpackage

>>> hw/rtl/ashk_evt_store.sv
// Event store: time and magnitude memory with one write and one registered read port.
module ashk_evt_store
   import ashk_pkg::*;
(
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [EIDX_W-1:0]      wr_addr,
   input  logic [31:0]            wr_time,
   input  logic [MAG_W-1:0]       wr_mag,
   input  logic [EIDX_W-1:0]      rd_addr,
   output logic [31:0]            rd_time,
   output logic [MAG_W-1:0]       rd_mag
);

   logic [31:0]      time_mem [MAX_EVENTS];
   logic [MAG_W-1:0] mag_mem  [MAX_EVENTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_addr] <= wr_time;
         mag_mem[wr_addr]  <= wr_mag;
      end
      rd_time <= time_mem[rd_addr];
      rd_mag  <= mag_mem[rd_addr];
   end

endmodule

>>> hw/rtl/ashk_alu.sv
// Shared iterative unit: one restoring square-root or division step per cycle while step is high.
module ashk_alu
   import ashk_pkg::*;
(
   input  logic                 clock,
   input  logic                 sqrt_load,
   input  logic [SQ_W-1:0]      sqrt_arg,
   input  logic                 div_load,
   input  logic [MAG_W+7:0]     div_num,
   input  logic [15:0]          div_den,
   input  logic                 step,
   output logic [MAG_W-1:0]     sqrt_res,
   output logic [MAG_W+7:0]     div_quo
);

   localparam int RW = SQ_W / 2;
   localparam int DW = MAG_W + 8;

   // shared remainder register and subtract
   logic [SQ_W+1:0]  rem_ff,  rem_in;
   logic [SQ_W-1:0]  src_ff,  src_in;
   logic [DW-1:0]    res_ff,  res_in;
   logic [15:0]      den_ff,  den_in;
   logic             mode_ff, mode_in;
   logic [SQ_W+1:0]  trial;
   logic [SQ_W+1:0]  sub_a, sub_b;

   always_comb begin
      if (mode_ff) begin
         sub_a = {rem_ff[SQ_W-1:0], src_ff[SQ_W-1 -: 2]};
         sub_b = {{(SQ_W+2-RW-2){1'b0}}, res_ff[RW-1:0], 2'b01};
      end else begin
         sub_a = {rem_ff[SQ_W:0], src_ff[DW-1]};
         sub_b = {{(SQ_W+2-16){1'b0}}, den_ff};
      end
      trial   = sub_a - sub_b;
      rem_in  = rem_ff;
      src_in  = src_ff;
      res_in  = res_ff;
      den_in  = den_ff;
      mode_in = mode_ff;
      if (sqrt_load) begin
         mode_in = 1'b1;
         rem_in  = '0;
         src_in  = sqrt_arg;
         res_in  = '0;
      end else if (div_load) begin
         mode_in = 1'b0;
         rem_in  = '0;
         src_in  = {{(SQ_W-DW){1'b0}}, div_num};
         res_in  = '0;
         den_in  = div_den;
      end else if (step) begin
         if (mode_ff)
            src_in = {src_ff[SQ_W-3:0], 2'b00};
         else
            src_in = {src_ff[SQ_W-1:DW], src_ff[DW-2:0], 1'b0};
         if (sub_a >= sub_b) begin
            rem_in = trial;
            res_in = {res_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = sub_a;
            res_in = {res_ff[DW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      src_ff  <= src_in;
      res_ff  <= res_in;
      den_ff  <= den_in;
      mode_ff <= mode_in;
   end

   assign sqrt_res = res_ff[MAG_W-1:0];
   assign div_quo  = res_ff;

endmodule

>>> hw/rtl/accel_shake_detector.sv
// Top level: sequencer, sample state and result register of the shake detector.
// Beat flow: restart beats go straight to the result; other beats walk the live events for
// expiry, take a new event's root, compact the store when the oldest is dropped, scan for
// the maximum and divide for the level when needed; the result waits while it is stalled.
// Throughput: one beat at a time; the next beat is taken the cycle after the result loads.
// Reset: synchronous, active high; sets registers to defaults, clears previous sample, signs and count.
module accel_shake_detector
   import ashk_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]       csr_wdata
);

   localparam int SQRT_STEPS = SQ_W / 2;
   localparam int DIV_STEPS  = MAG_W + 8;
   localparam int STEP_W     = $clog2(DIV_STEPS + 1);

   state_type state_ff, state_in;

   logic [15:0] min_mag_ff, min_mag_in;
   logic [4:0]  req_evt_ff, req_evt_in;
   logic [15:0] window_ff,  window_in;

   logic signed [SAMPLE_BITS-1:0] prev_ff [3];
   logic signed [SAMPLE_BITS-1:0] prev_in [3];
   logic [1:0]  psign_ff [3];
   logic [1:0]  psign_in [3];

   req_type     cur_ff, cur_in;
   logic [SQ_W-1:0]  sq_ff, sq_in;
   logic [1:0]       ax_ff, ax_in;
   logic             chg_ff, chg_in;
   logic [ECNT_W-1:0] live_ff, live_in;
   logic [ECNT_W-1:0] rd_ff, rd_in;
   logic [ECNT_W-1:0] wr_ff, wr_in;
   logic [MAG_W-1:0]  max_ff, max_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              add_ff, add_in;
   logic              ovf_ff, ovf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           out_ff, out_in;
   rsp_type           rsp_ff, rsp_in;

   logic               st_wr;
   logic [EIDX_W-1:0]  st_waddr;
   logic [31:0]        st_wtime;
   logic [MAG_W-1:0]   st_wmag;
   logic [EIDX_W-1:0]  st_raddr;
   logic [31:0]        st_rtime;
   logic [MAG_W-1:0]   st_rmag;

   logic              sqrt_load, div_load, alu_step;
   logic [MAG_W-1:0]  sqrt_res;
   logic [MAG_W+7:0]  div_quo;

   logic signed [SAMPLE_BITS-1:0] s_ax [3];
   logic signed [SAMPLE_BITS:0]   diff;
   logic [SAMPLE_BITS:0]          adiff;
   logic [SQ_W-1:0]               adsq;
   logic [31:0]                   thr;
   logic                          any_chg;
   logic [31:0]                   age;

   ashk_evt_store u_store (
      .clock   (clock),
      .wr_en   (st_wr),
      .wr_addr (st_waddr),
      .wr_time (st_wtime),
      .wr_mag  (st_wmag),
      .rd_addr (st_raddr),
      .rd_time (st_rtime),
      .rd_mag  (st_rmag)
   );

   ashk_alu u_alu (
      .clock     (clock),
      .sqrt_load (sqrt_load),
      .sqrt_arg  (sq_ff),
      .div_load  (div_load),
      .div_num   ({max_ff, 8'd0}),
      .div_den   (min_mag_ff),
      .step      (alu_step),
      .sqrt_res  (sqrt_res),
      .div_quo   (div_quo)
   );

   assign s_ax[0] = cur_ff.accel_x[SAMPLE_BITS-1:0];
   assign s_ax[1] = cur_ff.accel_y[SAMPLE_BITS-1:0];
   assign s_ax[2] = cur_ff.accel_z[SAMPLE_BITS-1:0];
   assign thr     = min_mag_ff * min_mag_ff;
   assign age     = cur_ff.time_ms - st_rtime;

   always_comb begin
      any_chg = 1'b0;
      for (int i = 0; i < 3; i++)
         if (sign_of(s_ax[i]) != psign_ff[i])
            any_chg = 1'b1;
      diff  = {s_ax[ax_ff][SAMPLE_BITS-1], s_ax[ax_ff]}
              - {prev_ff[ax_ff][SAMPLE_BITS-1], prev_ff[ax_ff]};
      adiff = diff[SAMPLE_BITS] ? (~diff + 1'b1) : diff;
      adsq  = adiff * adiff;
   end

   always_comb begin
      state_in     = state_ff;
      min_mag_in   = min_mag_ff;
      req_evt_in   = req_evt_ff;
      window_in    = window_ff;
      prev_in      = prev_ff;
      psign_in     = psign_ff;
      cur_in       = cur_ff;
      sq_in        = sq_ff;
      ax_in        = ax_ff;
      chg_in       = chg_ff;
      live_in      = live_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      max_in       = max_ff;
      cnt_in       = cnt_ff;
      add_in       = add_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      rsp_in       = rsp_ff;
      st_wr        = 1'b0;
      st_waddr     = wr_ff[EIDX_W-1:0];
      st_wtime     = st_rtime;
      st_wmag      = st_rmag;
      st_raddr     = rd_ff[EIDX_W-1:0];
      sqrt_load    = 1'b0;
      div_load     = 1'b0;
      alu_step     = 1'b0;
      req_stall    = 1'b1;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_MIN_MAG: min_mag_in = csr_wdata;
            CSR_REQ_EVT: req_evt_in = csr_wdata[4:0];
            CSR_WINDOW:  window_in  = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall)
         rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cur_in   = req_data;
               state_in = ST_SQ;
               sq_in    = '0;
               ax_in    = 2'd0;
            end
         end
         ST_SQ: begin
            if (cur_ff.restart) begin
               live_in = '0;
               for (int i = 0; i < 3; i++) begin
                  prev_in[i]  = s_ax[i];
                  psign_in[i] = SIGN_ZERO;
               end
               out_in   = '0;
               state_in = ST_OUT;
            end else begin
               // one axis per cycle
               sq_in = sq_ff + adsq;
               ax_in = ax_ff + 2'd1;
               if (ax_ff == 2'd2) begin
                  chg_in = any_chg;
                  if (any_chg)
                     for (int i = 0; i < 3; i++)
                        psign_in[i] = sign_of(s_ax[i]);
                  for (int i = 0; i < 3; i++)
                     prev_in[i] = s_ax[i];
                  rd_in    = '0;
                  wr_in    = '0;
                  state_in = ST_EXP_RD;
               end
            end
         end
         ST_EXP_RD: begin
            // memory read issued with rd_ff
            if (rd_ff == live_ff) begin
               live_in  = wr_ff;
               state_in = ST_ADD;
            end else
               state_in = ST_EXP_CHK;
         end
         ST_EXP_CHK: begin
            if (age <= {16'd0, window_ff}) begin
               st_wr  = 1'b1;
               wr_in  = wr_ff + 1'b1;
            end
            rd_in    = rd_ff + 1'b1;
            st_raddr = EIDX_W'(rd_ff + 1'b1);
            state_in = ST_EXP_RD;
         end
         ST_ADD: begin
            add_in = chg_ff && ({{(SQ_W-32){1'b0}}, thr} < sq_ff);
            ovf_in = live_ff == ECNT_W'(MAX_EVENTS);
            if (chg_ff && ({{(SQ_W-32){1'b0}}, thr} < sq_ff)) begin
               sqrt_load = 1'b1;
               cnt_in    = '0;
               state_in  = ST_SQRT;
            end else begin
               rd_in    = '0;
               max_in   = '0;
               st_raddr = '0;
               state_in = ST_MAX_RD;
            end
         end
         ST_SQRT: begin
            alu_step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(SQRT_STEPS)) begin
               alu_step = 1'b0;
               if (ovf_ff) begin
                  // drop oldest: compact the store by one
                  rd_in    = ECNT_W'(1);
                  wr_in    = '0;
                  st_raddr = EIDX_W'(1);
                  chg_in   = 1'b0;
                  max_in   = sqrt_res;
                  ovf_in   = 1'b0;
                  cnt_in   = STEP_W'(1);
                  state_in = ST_EXP_CHK;
                  st_wr    = 1'b0;
               end else begin
                  st_wr    = 1'b1;
                  st_waddr = live_ff[EIDX_W-1:0];
                  st_wtime = cur_ff.time_ms;
                  st_wmag  = sqrt_res;
                  live_in  = live_ff + 1'b1;
                  rd_in    = '0;
                  max_in   = '0;
                  st_raddr = '0;
                  state_in = ST_MAX_RD;
               end
            end
         end
         ST_MAX_RD: begin
            if (rd_ff == live_ff) begin
               if (live_ff < req_evt_ff || max_ff == '0) begin
                  out_in.shake_level = '0;
                  state_in = ST_OUT;
               end else if (min_mag_ff == '0) begin
                  out_in.shake_level = 16'hFFFF;
                  state_in = ST_OUT;
               end else begin
                  div_load = 1'b1;
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end
               out_in.event_count = 5'(live_ff);
               out_in.event_added = add_ff;
            end else
               state_in = ST_MAX_CHK;
         end
         ST_MAX_CHK: begin
            if (st_rmag > max_ff)
               max_in = st_rmag;
            rd_in    = rd_ff + 1'b1;
            st_raddr = EIDX_W'(rd_ff + 1'b1);
            state_in = ST_MAX_RD;
         end
         ST_DIV: begin
            alu_step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(DIV_STEPS)) begin
               alu_step = 1'b0;
               out_in.shake_level = (div_quo > (MAG_W+8)'(16'hFFFF)) ? 16'hFFFF
                                    : div_quo[15:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = out_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // overflow compaction reuses the expiry copy path with a forced append
      if (state_ff == ST_EXP_RD && chg_ff == 1'b0 && cnt_ff == STEP_W'(1)
          && rd_ff == live_ff) begin
         st_wr    = 1'b1;
         st_waddr = wr_ff[EIDX_W-1:0];
         st_wtime = cur_ff.time_ms;
         st_wmag  = max_ff;
         live_in  = wr_ff + 1'b1;
         cnt_in   = '0;
         rd_in    = '0;
         max_in   = '0;
         st_raddr = '0;
         state_in = ST_MAX_RD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_mag_ff   <= 16'd1000;
         req_evt_ff   <= 5'd3;
         window_ff    <= 16'd1000;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         for (int i = 0; i < 3; i++) begin
            prev_ff[i]  <= '0;
            psign_ff[i] <= SIGN_ZERO;
         end
      end else begin
         state_ff     <= state_in;
         min_mag_ff   <= min_mag_in;
         req_evt_ff   <= req_evt_in;
         window_ff    <= window_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         prev_ff      <= prev_in;
         psign_ff     <= psign_in;
      end
      cur_ff <= cur_in;
      sq_ff  <= sq_in;
      ax_ff  <= ax_in;
      chg_ff <= chg_in;
      rd_ff  <= rd_in;
      wr_ff  <= wr_in;
      max_ff <= max_in;
      add_ff <= add_in;
      ovf_ff <= ovf_in;
      out_ff <= out_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      live_ff <= ECNT_W'(MAX_EVENTS)) else $error("event count overflow");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> state_ff == ST_IDLE) else $error("ready outside idle");
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.event_count <= 5'(MAX_EVENTS)) else $error("bad count");
   a_restart_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_added |-> rsp_data.event_count != '0)
      else $error("added with no events");
`endif

endmodule

>>> bench/accel_shake_detector_test.sv
// Testbench for the shake detector: random and directed samples checked against a predictor.
module accel_shake_detector_test;
   import ashk_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   class shake_scoreboard;
      logic [15:0] thr_mag;
      logic [4:0]  need_events;
      logic [15:0] window;
      logic signed [15:0] last_smp [3];
      logic [1:0]  last_sgn [3];
      logic [31:0] ev_time [$];
      logic [16:0] ev_mag [$];
      rsp_type     pending [$];
      int          errors;
      int          checked;
      int          added_total;

      function void clear();
         thr_mag = 16'd1000;
         need_events = 5'd3;
         window = 16'd1000;
         for (int k = 0; k < 3; k++) begin
            last_smp[k] = '0;
            last_sgn[k] = SIGN_ZERO;
         end
         ev_time.delete();
         ev_mag.delete();
         pending.delete();
         errors = 0;
         checked = 0;
         added_total = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
         case (idx)
            CSR_MIN_MAG: thr_mag = val;
            CSR_REQ_EVT: need_events = val[4:0];
            CSR_WINDOW:  window = val;
            default: ;
         endcase
      endfunction

      function logic [1:0] sgn(logic signed [15:0] v);
         if (v == 0) return SIGN_ZERO;
         if (v < 0) return SIGN_NEG;
         return SIGN_POS;
      endfunction

      function void note_sample(req_type r);
         logic signed [15:0] s [3];
         logic [1:0]  g [3];
         logic [63:0] sq, thr, root, bitv, n, mx, lvl;
         logic signed [63:0] d;
         bit          changed;
         rsp_type     o;
         int          k;
         s[0] = r.accel_x;
         s[1] = r.accel_y;
         s[2] = r.accel_z;
         o = '0;
         if (r.restart) begin
            ev_time.delete();
            ev_mag.delete();
            for (k = 0; k < 3; k++) begin
               last_smp[k] = s[k];
               last_sgn[k] = SIGN_ZERO;
            end
            pending = {pending, o};
            return;
         end
         sq = 0;
         for (k = 0; k < 3; k++) begin
            d = 64'(s[k]) - 64'(last_smp[k]);
            if (d < 0) d = -d;
            sq += d * d;
            g[k] = sgn(s[k]);
         end
         thr = 64'(thr_mag) * 64'(thr_mag);
         k = 0;
         while (k < ev_time.size()) begin
            if (32'(r.time_ms - ev_time[k]) > 32'(window)) begin
               ev_time.delete(k);
               ev_mag.delete(k);
            end else begin
               k++;
            end
         end
         changed = 0;
         for (k = 0; k < 3; k++)
            if (g[k] != last_sgn[k]) changed = 1;
         if (changed)
            for (k = 0; k < 3; k++) last_sgn[k] = g[k];
         if (changed && sq > thr) begin
            if (ev_time.size() >= MAX_EVENTS) begin
               void'(ev_time.pop_front());
               void'(ev_mag.pop_front());
            end
            n = sq;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0) begin
               if (n >= root + bitv) begin
                  n -= root + bitv;
                  root = (root >> 1) + bitv;
               end else begin
                  root >>= 1;
               end
               bitv >>= 2;
            end
            ev_time = {ev_time, r.time_ms};
            ev_mag = {ev_mag, root[16:0]};
            o.event_added = 1'b1;
         end
         for (k = 0; k < 3; k++) last_smp[k] = s[k];
         lvl = 0;
         if (ev_time.size() >= need_events) begin
            mx = 0;
            foreach (ev_mag[j]) if (ev_mag[j] > mx) mx = ev_mag[j];
            if (mx == 0) lvl = 0;
            else if (thr_mag == 0) lvl = 65535;
            else begin
               lvl = (mx << 8) / thr_mag;
               if (lvl > 65535) lvl = 65535;
            end
         end
         o.shake_level = lvl[15:0];
         o.event_count = 5'(ev_time.size());
         pending = {pending, o};
      endfunction

      function void check_result(rsp_type got);
         rsp_type w;
         if (pending.size() == 0) begin
            $error("result with nothing expected: %p", got);
            errors++;
            return;
         end
         w = pending.pop_front();
         checked++;
         if (got.event_added) added_total++;
         if (got.shake_level !== w.shake_level) begin
            $error("shake_level expected %0d actual %0d", w.shake_level, got.shake_level);
            errors++;
         end
         if (got.event_count !== w.event_count) begin
            $error("event_count expected %0d actual %0d", w.event_count, got.event_count);
            errors++;
         end
         if (got.event_added !== w.event_added) begin
            $error("event_added expected %0d actual %0d", w.event_added, got.event_added);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_type rsp_data;
   logic csr_wr_en = 0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MIN_MAG;
   logic [15:0] csr_wdata = '0;

   shake_scoreboard board = new();
   int idle_cycles = 0;
   int sent = 0;
   logic [31:0] now_ms = 0;
   logic signed [15:0] cur [3];

   always #2 clock = ~clock;

   accel_shake_detector i_dut (.*);

   function int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (req_valid && !req_stall) board.note_sample(req_data);
         if (rsp_valid && !rsp_stall) board.check_result(rsp_data);
         if (idle_cycles > 20000) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      int n;
      @(negedge clock);
      forever begin
         n = gap_len();
         if (n > 0 && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 0;
         repeat ($urandom_range(1, 20)) @(negedge clock);
      end
   end

   task automatic send_sample(logic signed [15:0] x, y, z, logic [31:0] t, logic rs,
                              bit pause = 1);
      int n;
      n = pause ? gap_len() : 0;
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(negedge clock);
      end
      req_data <= '{accel_x: x, accel_y: y, accel_z: z, time_ms: t, restart: rs};
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 0;
      board.set_reg(idx, val);
   endtask

   task automatic shake_burst(int len, int amp);
      logic signed [15:0] v [3];
      for (int i = 0; i < len; i++) begin
         now_ms += $urandom_range(0, 3) == 0 ? $urandom_range(0, 2000) : $urandom_range(0, 60);
         for (int k = 0; k < 3; k++) begin
            if ($urandom_range(0, 2) == 0) v[k] = cur[k];
            else begin
               v[k] = 16'(int'($urandom_range(0, amp)));
               if (cur[k] > 0) v[k] = -v[k];
            end
            if ($urandom_range(0, 15) == 0) v[k] = 16'($urandom);
            cur[k] = v[k];
         end
         send_sample(v[0], v[1], v[2], now_ms, $urandom_range(0, 40) == 0);
      end
   endtask

   task automatic n_phase(int ph);
      for (int b = 0; b < 10; b++) begin
         if ($urandom_range(0, 4) == 0)
            send_sample(16'($urandom), 16'($urandom), 16'($urandom), $urandom, 0);
         shake_burst($urandom_range(10, 30), ph == 1 ? 300 : 32767);
      end
   endtask

   initial begin
      board.clear();
      for (int k = 0; k < 3; k++) cur[k] = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: extremes, overflow of store, wrap of time
      send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 32'd0, 0, 0);
      send_sample(-16'sh8000, -16'sh8000, -16'sh8000, 32'd10, 0, 0);
      send_sample(16'sh7fff, 0, -16'sh8000, 32'd20, 0, 0);
      send_sample(0, 0, 0, 32'd30, 1, 0);
      send_sample(0, 0, 0, 32'd40, 0, 0);
      for (int i = 0; i < 18; i++)
         send_sample(i[0] ? 16'sh7000 : -16'sh7000, 16'sh0001, 0,
                     32'hffff_fff0 + 32'(i), 0, 0);
      send_sample(0, 0, 0, 32'h0000_1000, 0, 0);
      drain();
      write_reg(CSR_MIN_MAG, 16'd0);
      write_reg(CSR_REQ_EVT, 16'd0);
      write_reg(CSR_WINDOW, 16'd0);
      send_sample(0, 0, 0, 32'd5, 0);
      send_sample(100, 0, 0, 32'd5, 0);
      send_sample(-100, 0, 0, 32'd5, 0);
      send_sample(-100, 0, 0, 32'd9, 0);
      drain();
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: write_reg(CSR_MIN_MAG, 16'($urandom_range(1, 3000)));
            1: write_reg(CSR_MIN_MAG, 16'hffff);
            2: write_reg(CSR_MIN_MAG, 16'd1);
            default: write_reg(CSR_MIN_MAG, 16'($urandom_range(0, 200)));
         endcase
         write_reg(CSR_REQ_EVT, ph == 3 ? 16'd31 : ph == 5 ? 16'd16 :
                   16'($urandom_range(0, 5)));
         write_reg(CSR_WINDOW, ph == 1 ? 16'hffff : 16'($urandom_range(0, 3000)));
         n_phase(ph);
         drain();
      end
      $display("Sent %0d samples, %0d results checked, %0d shake events seen.",
               sent, board.checked, board.added_total);
      if (board.errors == 0 && board.pending.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
